// File: src/tasp_pkg.sv
package tasp_pkg;

  localparam int unsigned MaxEntries = 64;

  localparam int unsigned RegW  = 15;
  localparam int unsigned EdgeW = 15;
  localparam int unsigned TryW  = 17;
  localparam int unsigned PosW  = 14;
  localparam int unsigned IdW   = 7;
  localparam int unsigned UsedW = 29;
  localparam int unsigned AddrW = 3;

  localparam logic [RegW-1:0] InitReset = 15'd512;
  localparam logic [RegW-1:0] MaxReset  = 15'd4096;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_CLEAR = 3'd1,
    OP_PACK  = 3'd2,
    OP_QUERY = 3'd3,
    OP_STATS = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_KEY  = 9'b000000010,
    S_KEYW = 9'b000000100,
    S_SCAN = 9'b000001000,
    S_PCHK = 9'b000010000,
    S_PASS = 9'b000100000,
    S_PEND = 9'b001000000,
    S_QRD  = 9'b010000000,
    S_DONE = 9'b100000000
  } fsm_e;

endpackage

// File: src/tasp_if.sv
interface tasp_req_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     opcode;
  logic [tasp_pkg::RegW-1:0]      rect_width;
  logic [tasp_pkg::RegW-1:0]      rect_height;
  logic [tasp_pkg::IdW-1:0]       query_id;

  modport source (output valid, opcode, rect_width, rect_height, query_id, input ready);
  modport sink (input valid, opcode, rect_width, rect_height, query_id, output ready);
endinterface

interface tasp_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [tasp_pkg::IdW-1:0]       new_id;
  logic [tasp_pkg::PosW-1:0]      pos_x;
  logic [tasp_pkg::PosW-1:0]      pos_y;
  logic [tasp_pkg::EdgeW-1:0]     atlas_edge;
  logic [tasp_pkg::IdW-1:0]       entry_count;
  logic [tasp_pkg::UsedW-1:0]     used_pixels;

  modport source (output valid, status, new_id, pos_x, pos_y, atlas_edge, entry_count,
                  used_pixels, input ready);
  modport sink (input valid, status, new_id, pos_x, pos_y, atlas_edge, entry_count,
                used_pixels, output ready);
endinterface

// File: src/texture_atlas_shelf_packer.sv
// Channel  | Dir | Handshake    | Payload
// req_i    | in  | valid/ready  | opcode, rect_width, rect_height, query_id
// rsp_o    | out | valid/ready  | status, new_id, pos_x, pos_y, atlas_edge, entry_count,
//          |     |              | used_pixels
// apb      | in  | psel/penable | paddr, pwdata (reads on prdata)
//
// Allocate, clear, stats and unused codes answer straight from idle; query first reads
// the position memory. Pack ranks the N entries, then tries edges, one shelf pass per
// edge; the single read port of the size memory sets the pace of both steps.
// rst_ni clears the FSM, counts and config asynchronously; memories are not reset.
// A new request is taken in the idle state even while a result waits on rsp_o.
module texture_atlas_shelf_packer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tasp_req_if.sink                     req_i,
  tasp_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tasp_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned MAX_ENTRIES = tasp_pkg::MaxEntries;
  localparam int unsigned IdxW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned HgtW = tasp_pkg::RegW + CntW;
  localparam int unsigned CxW  = tasp_pkg::TryW + 1;
  localparam int unsigned RW   = tasp_pkg::RegW;

  // Configuration registers.
  logic [RW-1:0] init_q, max_q;
  logic          cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {17'd0, max_q} : {17'd0, init_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= tasp_pkg::InitReset;
      max_q  <= tasp_pkg::MaxReset;
    end else if (cfg_wr) begin
      if (paddr[2]) max_q <= pwdata[RW-1:0];
      else init_q <= pwdata[RW-1:0];
    end
  end

  // Memories: sizes {width, height}, sort order, positions {x, y}.
  logic [2*RW-1:0]                 wh_mem [MAX_ENTRIES];
  logic [IdxW-1:0]                 so_mem [MAX_ENTRIES];
  logic [2*tasp_pkg::PosW-1:0]     xy_mem [MAX_ENTRIES];
  logic [2*RW-1:0]                 wh_rd_q;
  logic [IdxW-1:0]                 so_rd_q;
  logic [2*tasp_pkg::PosW-1:0]     xy_rd_q;
  logic [IdxW-1:0]                 wh_raddr, xy_raddr, so_waddr, xy_waddr;
  logic                            wh_we, so_we, xy_we;
  logic [2*tasp_pkg::PosW-1:0]     xy_wdata;

  tasp_pkg::fsm_e state_q, state_d;
  logic [CntW-1:0] count_q, pcnt_q, k_q, i_q;
  logic            live_q;
  logic [RW-1:0]   edge_now_q, key_h_q, widest_q;
  logic [tasp_pkg::TryW-1:0]  try_q;
  logic [tasp_pkg::UsedW-1:0] used_q, sum_q;
  logic [2*RW-1:0] prod_q;
  logic            add_q;
  logic [IdxW-1:0] rank_q;
  logic            pv_q, s1_q, s2_q;
  logic [CntW-1:0] pi_q;
  logic [IdxW-1:0] e_q;
  logic [CxW-1:0]  cx_q;
  logic [HgtW-1:0] cy_q, shelf_q;
  logic [1:0]      pst_q;
  logic [tasp_pkg::IdW-1:0]  pid_q;
  logic [tasp_pkg::PosW-1:0] ppx_q, ppy_q;
  logic            hit_q;
  logic            out_valid_q;

  logic req_fire;
  assign req_i.ready = (state_q == tasp_pkg::S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Rank of the key: taller entries and equal entries of lower id go first.
  logic [RW-1:0]   rd_w, rd_h;
  logic            rank_inc;
  logic [IdxW-1:0] rank_fin;
  assign rd_w     = wh_rd_q[2*RW-1:RW];
  assign rd_h     = wh_rd_q[RW-1:0];
  assign rank_inc = (rd_h > key_h_q) || ((rd_h == key_h_q) && (pi_q < k_q));
  assign rank_fin = rank_q + IdxW'(rank_inc);

  // Shelf step for the entry whose size is on the read port.
  logic            new_shelf;
  logic [CxW-1:0]  px_c;
  logic [HgtW-1:0] py_c, total;
  assign new_shelf = (cx_q + CxW'(rd_w)) > CxW'(try_q);
  assign px_c      = new_shelf ? '0 : cx_q;
  assign py_c      = new_shelf ? cy_q + shelf_q : cy_q;
  assign total     = cy_q + shelf_q;

  always_comb begin
    wh_raddr = '0;
    case (state_q)
      tasp_pkg::S_KEY:  wh_raddr = k_q[IdxW-1:0];
      tasp_pkg::S_SCAN: wh_raddr = i_q[IdxW-1:0];
      tasp_pkg::S_PASS: wh_raddr = so_rd_q;
      default:          wh_raddr = '0;
    endcase
  end

  assign wh_we    = req_fire && (req_i.opcode == tasp_pkg::OP_ALLOC) &&
                    (req_i.rect_width != '0) && (req_i.rect_height != '0) &&
                    (32'(count_q) < MAX_ENTRIES);
  assign so_we    = (state_q == tasp_pkg::S_SCAN) && pv_q && (pi_q == count_q - 1'b1);
  assign so_waddr = rank_fin;
  assign xy_we    = (state_q == tasp_pkg::S_PASS) && s2_q;
  assign xy_waddr = e_q;
  assign xy_wdata = {px_c[tasp_pkg::PosW-1:0], py_c[tasp_pkg::PosW-1:0]};
  assign xy_raddr = IdxW'(req_i.query_id - 7'd1);

  always_ff @(posedge clk_i) begin
    if (wh_we) wh_mem[count_q[IdxW-1:0]] <= {req_i.rect_width, req_i.rect_height};
    wh_rd_q <= wh_mem[wh_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (so_we) so_mem[so_waddr] <= k_q[IdxW-1:0];
    so_rd_q <= so_mem[k_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (xy_we) xy_mem[xy_waddr] <= xy_wdata;
    xy_rd_q <= xy_mem[xy_raddr];
  end

  // Product of one entry, registered before the running sum.
  always_ff @(posedge clk_i) begin
    prod_q <= rd_w * rd_h;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tasp_pkg::S_IDLE: begin
        if (req_fire) begin
          if (req_i.opcode == tasp_pkg::OP_PACK && count_q != '0) state_d = tasp_pkg::S_KEY;
          else if (req_i.opcode == tasp_pkg::OP_QUERY) state_d = tasp_pkg::S_QRD;
          else state_d = tasp_pkg::S_DONE;
        end
      end
      tasp_pkg::S_KEY:  state_d = tasp_pkg::S_KEYW;
      tasp_pkg::S_KEYW: state_d = tasp_pkg::S_SCAN;
      tasp_pkg::S_SCAN: begin
        if (so_we) state_d = (k_q + 1'b1 == count_q) ? tasp_pkg::S_PCHK : tasp_pkg::S_KEY;
      end
      tasp_pkg::S_PCHK: begin
        state_d = (try_q > tasp_pkg::TryW'(max_q)) ? tasp_pkg::S_DONE : tasp_pkg::S_PASS;
      end
      tasp_pkg::S_PASS: begin
        if (k_q == count_q && !s1_q && s2_q) state_d = tasp_pkg::S_PEND;
      end
      tasp_pkg::S_PEND: begin
        state_d = (total <= HgtW'(try_q)) ? tasp_pkg::S_DONE : tasp_pkg::S_PCHK;
      end
      tasp_pkg::S_QRD:  state_d = tasp_pkg::S_DONE;
      tasp_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) state_d = tasp_pkg::S_IDLE;
      end
      default: state_d = tasp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tasp_pkg::S_IDLE;
      count_q     <= '0;
      pcnt_q      <= '0;
      live_q      <= 1'b0;
      edge_now_q  <= tasp_pkg::InitReset;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      add_q       <= 1'b0;
      pv_q        <= 1'b0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      add_q   <= (state_q == tasp_pkg::S_KEYW);
      if (add_q) sum_q <= sum_q + tasp_pkg::UsedW'(prod_q);
      if (out_valid_q && rsp_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        tasp_pkg::S_IDLE: begin
          if (req_fire) begin
            pst_q <= tasp_pkg::ST_OK;
            pid_q <= '0;
            ppx_q <= '0;
            ppy_q <= '0;
            hit_q <= (req_i.query_id != '0) && (32'(req_i.query_id) <= 32'(pcnt_q));
            case (req_i.opcode)
              tasp_pkg::OP_ALLOC: begin
                if (req_i.rect_width == '0 || req_i.rect_height == '0) begin
                  pst_q <= tasp_pkg::ST_ZERO;
                end else if (!wh_we) begin
                  pst_q <= tasp_pkg::ST_FULL;
                end else begin
                  count_q <= count_q + 1'b1;
                  pid_q   <= tasp_pkg::IdW'(count_q + 1'b1);
                end
              end
              tasp_pkg::OP_CLEAR: begin
                count_q <= '0;
                pcnt_q  <= '0;
                used_q  <= '0;
              end
              tasp_pkg::OP_PACK: begin
                if (count_q == '0) begin
                  if (live_q) begin
                    live_q     <= 1'b0;
                    edge_now_q <= init_q;
                  end
                end else begin
                  k_q      <= '0;
                  widest_q <= '0;
                  sum_q    <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        tasp_pkg::S_KEYW: begin
          key_h_q <= rd_h;
          if (rd_w > widest_q) widest_q <= rd_w;
          i_q    <= '0;
          rank_q <= '0;
          pv_q   <= 1'b0;
        end
        tasp_pkg::S_SCAN: begin
          pv_q <= (i_q != count_q);
          pi_q <= i_q;
          if (i_q != count_q) i_q <= i_q + 1'b1;
          if (pv_q) rank_q <= rank_fin;
          if (so_we) begin
            pv_q <= 1'b0;
            k_q  <= k_q + 1'b1;
            try_q <= (init_q > widest_q) ? tasp_pkg::TryW'(init_q)
                                         : tasp_pkg::TryW'(widest_q);
          end
        end
        tasp_pkg::S_PCHK: begin
          k_q     <= '0;
          cx_q    <= '0;
          cy_q    <= '0;
          shelf_q <= '0;
          s1_q    <= 1'b0;
          s2_q    <= 1'b0;
          if (try_q > tasp_pkg::TryW'(max_q)) begin
            pcnt_q <= '0;
            used_q <= '0;
            pst_q  <= tasp_pkg::ST_OVF;
          end
        end
        tasp_pkg::S_PASS: begin
          s1_q <= (k_q != count_q);
          if (k_q != count_q) k_q <= k_q + 1'b1;
          s2_q <= s1_q;
          e_q  <= so_rd_q;
          if (s2_q) begin
            cx_q <= px_c + CxW'(rd_w);
            cy_q <= py_c;
            if (new_shelf) shelf_q <= HgtW'(rd_h);
            else if (HgtW'(rd_h) > shelf_q) shelf_q <= HgtW'(rd_h);
          end
        end
        tasp_pkg::S_PEND: begin
          if (total <= HgtW'(try_q)) begin
            edge_now_q <= try_q[RW-1:0];
            live_q     <= 1'b1;
            pcnt_q     <= count_q;
            used_q     <= sum_q;
          end else begin
            try_q <= try_q << 1;
          end
        end
        tasp_pkg::S_QRD: begin
          if (hit_q) begin
            ppx_q <= xy_rd_q[2*tasp_pkg::PosW-1:tasp_pkg::PosW];
            ppy_q <= xy_rd_q[tasp_pkg::PosW-1:0];
          end
        end
        tasp_pkg::S_DONE: begin
          if (!out_valid_q || rsp_o.ready) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register, loaded when the transfer slot is free.
  always_ff @(posedge clk_i) begin
    if (state_q == tasp_pkg::S_DONE && (!out_valid_q || rsp_o.ready)) begin
      rsp_o.status      <= pst_q;
      rsp_o.new_id      <= pid_q;
      rsp_o.pos_x       <= ppx_q;
      rsp_o.pos_y       <= ppy_q;
      rsp_o.atlas_edge  <= edge_now_q;
      rsp_o.entry_count <= tasp_pkg::IdW'(count_q);
      rsp_o.used_pixels <= used_q;
    end
  end

  assign rsp_o.valid = out_valid_q;

endmodule
